@@ design/rtmp_pkg.sv @@
`timescale 1ns / 1ps

package rtmp_pkg;

	localparam int INDEX_WIDTH = 32;

	// Modulus and the width of one reduced element
	localparam int ELEM_W = 30;
	localparam logic [ELEM_W-1:0] PRIME = ELEM_W'(1000000007);

	// Positions up to this one are seed terms of value one
	localparam int SEED_TERMS = 3;

	// Matrix geometry
	localparam int MAT_N = 3;
	localparam int MAT_SIZE = MAT_N * MAT_N;
	localparam int CNT_W = $clog2(MAT_N);
	localparam int IDX_W = $clog2(MAT_SIZE);

	// Barrett reduction of a product below PRIME squared
	localparam int PROD_W = 2 * ELEM_W;
	localparam int MU_W = ELEM_W + 1;
	localparam int EST_W = 2 * MU_W;
	localparam int RED_W = ELEM_W + 2;
	localparam logic [PROD_W:0] MU_FULL = ((PROD_W + 1)'(1) << PROD_W) / (PROD_W + 1)'(PRIME);
	localparam logic [MU_W-1:0] BARRETT_MU = MU_FULL[MU_W-1:0];

	typedef logic [ELEM_W-1:0] elem_t;
	typedef elem_t [MAT_SIZE-1:0] mat_t;

	// Entry (r, c) lives at r * MAT_N + c
	localparam mat_t IDENT = {
		ELEM_W'(1), ELEM_W'(0), ELEM_W'(0),
		ELEM_W'(0), ELEM_W'(1), ELEM_W'(0),
		ELEM_W'(0), ELEM_W'(0), ELEM_W'(1)
	};
	localparam mat_t COMPANION = {
		ELEM_W'(0), ELEM_W'(1), ELEM_W'(0),
		ELEM_W'(0), ELEM_W'(0), ELEM_W'(1),
		ELEM_W'(1), ELEM_W'(0), ELEM_W'(1)
	};

	// Jump conditions
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] COND_NEVER     = 3'd0;
	localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd1;
	localparam logic [COND_W-1:0] COND_NO_START  = 3'd2;
	localparam logic [COND_W-1:0] COND_EXP_ZERO  = 3'd3;
	localparam logic [COND_W-1:0] COND_BIT_CLEAR = 3'd4;
	localparam logic [COND_W-1:0] COND_MORE      = 3'd5;
	localparam logic [COND_W-1:0] COND_PIPE_BUSY = 3'd6;

	// Program steps
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] S_IDLE      = 4'd0;
	localparam logic [PC_W-1:0] S_TEST_Z    = 4'd1;
	localparam logic [PC_W-1:0] S_TEST_B    = 4'd2;
	localparam logic [PC_W-1:0] S_MUL       = 4'd3;
	localparam logic [PC_W-1:0] S_MUL_DRAIN = 4'd4;
	localparam logic [PC_W-1:0] S_MUL_COPY  = 4'd5;
	localparam logic [PC_W-1:0] S_SQ        = 4'd6;
	localparam logic [PC_W-1:0] S_SQ_DRAIN  = 4'd7;
	localparam logic [PC_W-1:0] S_SQ_COPY   = 4'd8;
	localparam logic [PC_W-1:0] S_SUM       = 4'd9;
	localparam logic [PC_W-1:0] S_SUM_DRAIN = 4'd10;
	localparam logic [PC_W-1:0] S_DONE      = 4'd11;

	typedef struct packed {
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
		logic              load;
		logic              issue;
		logic              left_acc;
		logic              rhs_one;
		logic              row_only;
		logic              copy_acc;
		logic              copy_base;
		logic              done;
	} ctrl_t;

	typedef struct packed {
		logic exp_zero;
		logic exp_bit0;
		logic issue_last;
		logic pipe_busy;
	} stat_t;

	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
		logic [CNT_W-1:0] dot;
	} tag_t;

	function automatic logic [IDX_W-1:0] mat_idx(logic [CNT_W-1:0] r, logic [CNT_W-1:0] c);
		return IDX_W'(r) * IDX_W'(MAT_N) + IDX_W'(c);
	endfunction

	// Control store
	function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '0;
		w.cond = COND_NEVER;
		w.target = S_IDLE;
		case (pc)
			S_IDLE: begin
				w.load = 1'b1;
				w.cond = COND_NO_START;
				w.target = S_IDLE;
			end
			S_TEST_Z: begin
				w.cond = COND_EXP_ZERO;
				w.target = S_SUM;
			end
			S_TEST_B: begin
				w.cond = COND_BIT_CLEAR;
				w.target = S_SQ;
			end
			S_MUL: begin
				w.issue = 1'b1;
				w.left_acc = 1'b1;
				w.cond = COND_MORE;
				w.target = S_MUL;
			end
			S_MUL_DRAIN: begin
				w.cond = COND_PIPE_BUSY;
				w.target = S_MUL_DRAIN;
			end
			S_MUL_COPY: begin
				w.copy_acc = 1'b1;
			end
			S_SQ: begin
				w.issue = 1'b1;
				w.cond = COND_MORE;
				w.target = S_SQ;
			end
			S_SQ_DRAIN: begin
				w.cond = COND_PIPE_BUSY;
				w.target = S_SQ_DRAIN;
			end
			S_SQ_COPY: begin
				w.copy_base = 1'b1;
				w.cond = COND_ALWAYS;
				w.target = S_TEST_Z;
			end
			S_SUM: begin
				w.issue = 1'b1;
				w.left_acc = 1'b1;
				w.rhs_one = 1'b1;
				w.row_only = 1'b1;
				w.cond = COND_MORE;
				w.target = S_SUM;
			end
			S_SUM_DRAIN: begin
				w.cond = COND_PIPE_BUSY;
				w.target = S_SUM_DRAIN;
			end
			S_DONE: begin
				w.done = 1'b1;
				w.cond = COND_ALWAYS;
				w.target = S_IDLE;
			end
			default: begin
				w.cond = COND_ALWAYS;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

@@ design/recurrence_term_by_matrix_power_unit.sv @@
`timescale 1ns / 1ps
// Term n of a(n) = a(n-1) + a(n-3), a1 = a2 = a3 = 1, modulo 1000000007.
// Command channel: drive index and pulse start while busy is low; the item
// is taken on that edge and busy rises on the next cycle.
// Result channel: done is high for exactly one cycle with term valid; the
// receiver has no way to stall it, so sample term while done is high.
// Busy drops the cycle after done, and the next start may follow at once.
// One item at a time. The 3x3 companion matrix is raised to the power n-3
// by square-and-multiply, the exponent walked from its low bit upward.
// Every matrix product issues 27 multiply-reduce beats into one shared
// six-stage multiplier pipeline, then drains it.
// Each exponent bit takes a zero test, a bit test, a multiply into the
// running product when the bit is set, and a square of the base; a last
// zero test then leads to the row sum and the result beat. Positions up
// to three go straight from that test to the row sum.
// Reset (arst_n low) returns the sequencer to idle and drops any item in
// flight; no result is produced for it.

module recurrence_term_by_matrix_power_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [rtmp_pkg::INDEX_WIDTH-1:0] index,
	output logic                             done,
	output logic [rtmp_pkg::ELEM_W-1:0]      term
);
	import rtmp_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	rtmp_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.ctrl  (ctrl),
		.busy  (busy)
	);

	rtmp_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.index (index),
		.ctrl  (ctrl),
		.stat  (stat),
		.term  (term)
	);

	assign done = ctrl.done;

endmodule

@@ design/rtmp_mulred.sv @@
`timescale 1ns / 1ps

module rtmp_mulred (
	input  logic           clk,
	input  logic           arst_n,
	input  rtmp_pkg::elem_t lhs,
	input  rtmp_pkg::elem_t rhs,
	input  rtmp_pkg::tag_t  tag_in,
	output rtmp_pkg::elem_t prod,
	output rtmp_pkg::tag_t  tag_out,
	output logic           busy
);
	import rtmp_pkg::*;

	localparam logic [RED_W-1:0] PRIME_R  = RED_W'(PRIME);
	localparam logic [RED_W-1:0] PRIME_X2 = RED_W'(PRIME) << 1;

	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;

	elem_t             a_s1, b_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [EST_W-1:0]  est_s3;
	logic [RED_W-1:0]  low_s3, low_s4, qp_s4, rem_s5;
	elem_t             res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
		end
	end

	// Barrett: quotient estimate is at most two short, so the remainder stays below 3p
	always_ff @(posedge clk) begin
		a_s1    <= lhs;
		b_s1    <= rhs;
		prod_s2 <= PROD_W'(a_s1) * PROD_W'(b_s1);
		est_s3  <= EST_W'(prod_s2[PROD_W-1:ELEM_W-1]) * EST_W'(BARRETT_MU);
		low_s3  <= prod_s2[RED_W-1:0];
		qp_s4   <= RED_W'(est_s3[EST_W-1:MU_W]) * PRIME_R;
		low_s4  <= low_s3;
		rem_s5  <= low_s4 - qp_s4;
		if (rem_s5 >= PRIME_X2) begin
			res_s6 <= ELEM_W'(rem_s5 - PRIME_X2);
		end else if (rem_s5 >= PRIME_R) begin
			res_s6 <= ELEM_W'(rem_s5 - PRIME_R);
		end else begin
			res_s6 <= ELEM_W'(rem_s5);
		end
	end

	assign prod    = res_s6;
	assign tag_out = tag_s6;
	assign busy    = tag_s1.valid | tag_s2.valid | tag_s3.valid
		| tag_s4.valid | tag_s5.valid | tag_s6.valid;

endmodule

@@ design/rtmp_dp.sv @@
`timescale 1ns / 1ps

module rtmp_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rtmp_pkg::INDEX_WIDTH-1:0] index,
	input  rtmp_pkg::ctrl_t                  ctrl,
	output rtmp_pkg::stat_t                  stat,
	output rtmp_pkg::elem_t                  term
);
	import rtmp_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAT_N - 1);

	logic [INDEX_WIDTH-1:0] exp_q;
	mat_t                   acc_q, basel_q, baser_q, tmp_q;
	logic [CNT_W-1:0]       row_q, col_q, dot_q;
	elem_t                  dot_acc_q;

	elem_t       lhs, rhs, prod;
	tag_t        tag_in, tag_out;
	logic        pipe_busy;
	logic        last_dot, issue_last;
	logic [ELEM_W:0] sum_wide;
	elem_t       sum_mod;

	assign last_dot   = dot_q == CNT_MAX;
	assign issue_last = last_dot && (ctrl.row_only || (row_q == CNT_MAX && col_q == CNT_MAX));

	// Left operand comes from the running product or the base copy; right from the other copy, or one for the row sum
	assign lhs = ctrl.left_acc ? acc_q[mat_idx(row_q, dot_q)] : basel_q[mat_idx(row_q, dot_q)];
	assign rhs = ctrl.rhs_one ? ELEM_W'(1) : baser_q[mat_idx(dot_q, col_q)];

	always_comb begin
		tag_in.valid = ctrl.issue;
		tag_in.row   = row_q;
		tag_in.col   = col_q;
		tag_in.dot   = dot_q;
	end

	rtmp_mulred u_mulred (
		.clk    (clk),
		.arst_n (arst_n),
		.lhs    (lhs),
		.rhs    (rhs),
		.tag_in (tag_in),
		.prod   (prod),
		.tag_out(tag_out),
		.busy   (pipe_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			dot_q <= '0;
		end else if (ctrl.load && start) begin
			row_q <= '0;
			col_q <= '0;
			dot_q <= '0;
		end else if (ctrl.issue) begin
			dot_q <= last_dot ? '0 : dot_q + 1'b1;
			if (last_dot && !ctrl.row_only) begin
				col_q <= (col_q == CNT_MAX) ? '0 : col_q + 1'b1;
				if (col_q == CNT_MAX) begin
					row_q <= (row_q == CNT_MAX) ? '0 : row_q + 1'b1;
				end
			end
		end
	end

	// Restart the dot product on its first beat
	always_comb begin
		sum_wide = ((tag_out.dot == '0) ? '0 : {1'b0, dot_acc_q}) + {1'b0, prod};
		if (sum_wide >= (ELEM_W + 1)'(PRIME)) begin
			sum_mod = ELEM_W'(sum_wide - (ELEM_W + 1)'(PRIME));
		end else begin
			sum_mod = sum_wide[ELEM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (tag_out.valid) begin
			dot_acc_q <= sum_mod;
			if (tag_out.dot == CNT_MAX) begin
				tmp_q[mat_idx(tag_out.row, tag_out.col)] <= sum_mod;
			end
		end
		if (ctrl.load && start) begin
			acc_q   <= IDENT;
			basel_q <= COMPANION;
			baser_q <= COMPANION;
			exp_q   <= (index > INDEX_WIDTH'(SEED_TERMS)) ? index - INDEX_WIDTH'(SEED_TERMS) : '0;
		end
		if (ctrl.copy_acc) begin
			acc_q <= tmp_q;
		end
		if (ctrl.copy_base) begin
			basel_q <= tmp_q;
			baser_q <= tmp_q;
			exp_q   <= exp_q >> 1;
		end
	end

	always_comb begin
		stat.exp_zero   = exp_q == '0;
		stat.exp_bit0   = exp_q[0];
		stat.issue_last = issue_last;
		stat.pipe_busy  = pipe_busy;
	end

	assign term = tmp_q[0];

endmodule

@@ design/rtmp_seq.sv @@
`timescale 1ns / 1ps

module rtmp_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  rtmp_pkg::stat_t stat,
	output rtmp_pkg::ctrl_t ctrl,
	output logic            busy
);
	import rtmp_pkg::*;

	logic [PC_W-1:0] pc_q, pc_next;
	ctrl_t           word;
	logic            take;

	always_comb begin
		word = ucode(pc_q);
		case (word.cond)
			COND_NEVER:     take = 1'b0;
			COND_ALWAYS:    take = 1'b1;
			COND_NO_START:  take = !start;
			COND_EXP_ZERO:  take = stat.exp_zero;
			COND_BIT_CLEAR: take = !stat.exp_bit0;
			COND_MORE:      take = !stat.issue_last;
			COND_PIPE_BUSY: take = stat.pipe_busy;
			default:        take = 1'b0;
		endcase
		pc_next = take ? word.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	assign ctrl = word;
	assign busy = pc_q != S_IDLE;

endmodule

@@ design/rtmp_chk.sv @@
`timescale 1ns / 1ps

module rtmp_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [rtmp_pkg::ELEM_W-1:0] term
);
	import rtmp_pkg::*;

	// Result is always fully reduced
	a_term_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (term < PRIME))
		else $error("term not reduced");

	// A result belongs to an accepted command
	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done outside a command");

	// Back to idle straight after the result beat
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("still busy after done");

	// A taken command keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted command not held");

	// Busy only rises on an accepted command
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without start");

endmodule

bind recurrence_term_by_matrix_power_unit rtmp_chk u_chk (.*);

@@ tb/tb_recurrence_term_by_matrix_power_unit.sv @@
`timescale 1ns / 1ps

module tb_recurrence_term_by_matrix_power_unit;

	import rtmp_pkg::*;

	localparam int STALL_LIMIT = 10000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [63:0] MODULUS = 64'(PRIME);

	typedef logic [2:0][2:0][63:0] mat3_t;

	typedef struct {
		logic [INDEX_WIDTH-1:0] index;
		elem_t                  term;
	} term_beat_t;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [INDEX_WIDTH-1:0] index;
	logic                   done;
	elem_t                  term;

	term_beat_t pending_terms[$];
	int         errors;
	int         stall_cycles;
	int         idle_pct;

	recurrence_term_by_matrix_power_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.index  (index),
		.done   (done),
		.term   (term)
	);

	always #5 clk = ~clk;

	function automatic mat3_t mat_product(input mat3_t a, input mat3_t b);
		mat3_t       r;
		logic [63:0] acc;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				acc = '0;
				for (int k = 0; k < 3; k++)
					acc = (acc + a[i][k] * b[k][j]) % MODULUS;
				r[i][j] = acc;
			end
		end
		return r;
	endfunction

	function automatic elem_t predict_term(input logic [INDEX_WIDTH-1:0] n);
		mat3_t       power;
		mat3_t       step;
		logic [63:0] expo;
		if (n <= INDEX_WIDTH'(SEED_TERMS))
			return elem_t'(1);
		power = '0;
		step = '0;
		for (int i = 0; i < 3; i++)
			power[i][i] = 64'd1;
		// a(n) = a(n-1) + a(n-3) as a step on (a(n), a(n-1), a(n-2))
		step[0][0] = 64'd1;
		step[0][2] = 64'd1;
		step[1][0] = 64'd1;
		step[2][1] = 64'd1;
		expo = 64'(n) - 64'(SEED_TERMS);
		while (expo != 0) begin
			if (expo[0])
				power = mat_product(power, step);
			step = mat_product(step, step);
			expo = expo >> 1;
		end
		return elem_t'((power[0][0] + power[0][1] + power[0][2]) % MODULUS);
	endfunction

	// Check results first, then log the beat taken on this edge
	always @(posedge clk) begin
		term_beat_t want;
		if (done) begin
			if (pending_terms.size() == 0) begin
				$error("term: unexpected result %0d with nothing outstanding", term);
				errors++;
			end else begin
				want = pending_terms.pop_front();
				if (term !== want.term) begin
					$error("term (index %0d): expected %0d, actual %0d",
						want.index, want.term, term);
					errors++;
				end
			end
		end
		if (start && !busy) begin
			want.index = index;
			want.term = predict_term(index);
			pending_terms.push_back(want);
		end
		if (done || (start && !busy))
			stall_cycles = 0;
		else
			stall_cycles++;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("tb_recurrence_term_by_matrix_power_unit: done, errors");
		$finish;
	end

	// Leave start high after the beat so back-to-back commands need no re-raise
	task automatic send_index(input logic [INDEX_WIDTH-1:0] value);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		index <= value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Step past the edge of the last beat so it is logged before the queue is read
	task automatic wait_for_drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_terms.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_seed_positions();
		for (int n = 0; n <= 7; n++)
			send_index(INDEX_WIDTH'(n));
		send_index(INDEX_WIDTH'(10));
	endtask

	task automatic test_index_extremes();
		// hold off until the unit has emptied, then hit wide and sparse exponents
		wait_for_drain();
		@(posedge clk);
		send_index('1);
		send_index({{(INDEX_WIDTH-1){1'b1}}, 1'b0});
		send_index({1'b1, {(INDEX_WIDTH-1){1'b0}}});
		send_index({1'b1, {(INDEX_WIDTH-3){1'b0}}, 2'b11});
		send_index({1'b0, {(INDEX_WIDTH-1){1'b1}}});
		send_index({(INDEX_WIDTH/2){2'b01}});
		send_index({(INDEX_WIDTH/2){2'b10}});
		send_index(INDEX_WIDTH'(32'h0000_0103));
		send_index(INDEX_WIDTH'(32'h0001_0003));
	endtask

	task automatic test_random_indices(input int count, input int pct);
		logic [INDEX_WIDTH-1:0] value;
		int                     pick;
		int                     bits;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			// mostly short exponents, now and then up to the full width
			if (pick < 6)
				bits = 0;
			else if (pick < 70)
				bits = $urandom_range(12, 3);
			else if (pick < 94)
				bits = $urandom_range(24, 13);
			else
				bits = $urandom_range(INDEX_WIDTH, 25);
			if (bits == 0) begin
				value = INDEX_WIDTH'($urandom_range(SEED_TERMS));
			end else begin
				value = INDEX_WIDTH'($urandom);
				if (bits < INDEX_WIDTH)
					value = value & INDEX_WIDTH'((65'd1 << bits) - 1);
				value[bits-1] = 1'b1;
			end
			send_index(value);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		index = '0;
		errors = 0;
		stall_cycles = 0;
		idle_pct = 25;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_seed_positions();
		test_index_extremes();
		test_random_indices(104, 25);
		wait_for_drain();
		test_random_indices(104, 80);
		test_random_indices(104, 0);

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_recurrence_term_by_matrix_power_unit: done, clean");
		else
			$display("tb_recurrence_term_by_matrix_power_unit: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
design/rtmp_pkg.sv
design/rtmp_mulred.sv
design/rtmp_dp.sv
design/rtmp_seq.sv
design/recurrence_term_by_matrix_power_unit.sv
design/rtmp_chk.sv
tb/tb_recurrence_term_by_matrix_power_unit.sv
